[design/ptc_pkg.sv]
// Shared types and constants for the pressure/temperature/humidity compensation core.
// No dependencies; ptc_div, ptc_front, ptc_back and the top level refer to it by scoped names.
package ptc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int DIV_BITS   = 64;
    localparam int DIVR_W     = 31;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CALIB       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_HUM_CALIB  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_CALIB        = 3'd4;

    localparam logic signed [63:0] PRESS_TFINE_OFS = 64'sd128000;
    localparam logic signed [63:0] PRESS_BIAS      = 64'sh0000_8000_0000_0000;
    localparam logic [20:0]        PRESS_FULL      = 21'd1048576;
    localparam logic [63:0]        PRESS_SCALE     = 64'd3125;
    localparam logic signed [31:0] HUM_TFINE_OFS   = 32'sd76800;
    localparam logic signed [31:0] HUM_MAX         = 32'sd419430400;
    localparam logic signed [31:0] TEMP_ROUND      = 32'sd128;
    localparam logic signed [31:0] HUM_ROUND_L     = 32'sd16384;
    localparam logic signed [31:0] HUM_OFS_B       = 32'sd32768;
    localparam logic signed [31:0] HUM_OFS_C       = 32'sd2097152;
    localparam logic signed [31:0] HUM_ROUND_R     = 32'sd8192;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
        logic [7:0]         h1;
        logic signed [15:0] h2;
        logic [7:0]         h3;
        logic signed [11:0] h4;
        logic signed [11:0] h5;
        logic signed [7:0]  h6;
    } calib_t;

    typedef struct packed {
        logic [19:0] raw_pressure;
        logic [19:0] raw_temperature;
        logic [15:0] raw_humidity;
    } raw_t;

    typedef struct packed {
        logic signed [31:0] temp;
        logic [16:0]        hum;
        logic               zero;
        logic               neg;
    } side_t;

endpackage

[design/ptc_mul64.sv]
// Two-stage 64x64 multiplier giving the low 64 bits of the product.
// Built from three 32x32 partial products; uses no package items.
module ptc_mul64
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0] ll_next;
    logic [31:0] lh_next;
    logic [31:0] hl_next;
    logic [63:0] ll_reg;
    logic [31:0] lh_reg;
    logic [31:0] hl_reg;
    logic [63:0] p_reg;
    logic [63:0] p_next;

    assign ll_next = a[31:0] * b[31:0];
    assign lh_next = a[31:0] * b[63:32];
    assign hl_next = a[63:32] * b[31:0];
    assign p_next  = ll_reg + {lh_reg + hl_reg, 32'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

[design/ptc_div.sv]
// Pipelined unsigned 64-by-31-bit restoring divider, one quotient bit per stage.
// Depends on ptc_pkg for the side-payload type and widths.
module ptc_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_vld,
    input  logic [63:0]                  num,
    input  logic [ptc_pkg::DIVR_W-1:0]   den,
    input  ptc_pkg::side_t               in_side,
    output logic                         out_vld,
    output logic [63:0]                  quo,
    output ptc_pkg::side_t               out_side
);

    localparam int N = ptc_pkg::DIV_BITS;
    localparam int W = ptc_pkg::DIVR_W;

    logic [63:0]          n_reg    [N];
    logic [W-1:0]         r_reg    [N];
    logic [W-1:0]         d_reg    [N];
    ptc_pkg::side_t       side_reg [N];
    logic [N-1:0]         vld_reg;

    logic [63:0]          n_src    [N];
    logic [W-1:0]         r_src    [N];
    logic [W-1:0]         d_src    [N];
    ptc_pkg::side_t       side_src [N];
    logic [N-1:0]         vld_src;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_stage
            logic [W:0]   trial;
            logic [W:0]   diff;
            logic         ge;
            logic [W-1:0] r_next;
            logic [63:0]  n_next;

            if (i == 0)
            begin : g_first
                assign n_src[i]    = num;
                assign r_src[i]    = '0;
                assign d_src[i]    = den;
                assign side_src[i] = in_side;
                assign vld_src[i]  = in_vld;
            end
            else
            begin : g_rest
                assign n_src[i]    = n_reg[i-1];
                assign r_src[i]    = r_reg[i-1];
                assign d_src[i]    = d_reg[i-1];
                assign side_src[i] = side_reg[i-1];
                assign vld_src[i]  = vld_reg[i-1];
            end

            assign trial  = {r_src[i], n_src[i][63]};
            assign diff   = trial - {1'b0, d_src[i]};
            assign ge     = trial >= {1'b0, d_src[i]};
            assign r_next = ge ? diff[W-1:0] : trial[W-1:0];
            assign n_next = {n_src[i][62:0], ge};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[i]    <= n_next;
                    r_reg[i]    <= r_next;
                    d_reg[i]    <= d_src[i];
                    side_reg[i] <= side_src[i];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[i] <= vld_src[i];
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[N-1];
    assign quo      = n_reg[N-1];
    assign out_side = side_reg[N-1];

endmodule

[design/ptc_front.sv]
// Input queue: accepts raw readings and holds them until the compute pipeline takes them.
// Depends on ptc_pkg for the raw item type.
module ptc_front
#(
    parameter int DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  ptc_pkg::raw_t in_item,
    output logic          q_vld,
    output ptc_pkg::raw_t q_item,
    input  logic          q_take
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ptc_pkg::raw_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push;
    logic             pop;

    assign in_stall = (cnt_reg == CNT_W'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_vld    = (cnt_reg != '0);
    assign pop      = q_take && q_vld;
    assign q_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[design/ptc_back.sv]
// Compute pipeline: temperature, pressure (64-bit with divider) and humidity, plus output register.
// Depends on ptc_pkg, ptc_mul64 and ptc_div.
module ptc_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  ptc_pkg::calib_t     cal,
    input  logic                in_vld,
    input  ptc_pkg::raw_t       in_item,
    output logic                in_take,
    output logic                out_vld,
    input  logic                out_stall,
    output logic signed [31:0]  temperature,
    output logic [31:0]         pressure,
    output logic [16:0]         humidity
);

    logic en;
    logic out_vld_reg;

    assign en      = !out_vld_reg || !out_stall;
    assign in_take = en;

    // calibration words widened for the 64-bit datapath
    logic signed [63:0] p2_w, p3_w, p4_w, p5_w, p6_w, p7_w, p8_w, p9_w;
    logic [63:0]        p1_w;
    assign p1_w = {48'd0, cal.p1};
    assign p2_w = 64'(cal.p2);
    assign p3_w = 64'(cal.p3);
    assign p4_w = 64'(cal.p4);
    assign p5_w = 64'(cal.p5);
    assign p6_w = 64'(cal.p6);
    assign p7_w = 64'(cal.p7);
    assign p8_w = 64'(cal.p8);
    assign p9_w = 64'(cal.p9);

    // ---------------- temperature ----------------
    logic signed [18:0] xt;
    logic signed [34:0] va_full;
    logic signed [17:0] td;
    logic signed [35:0] dd_full;
    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [31:0] va_reg, dd_reg;
    logic [19:0]        rp1_reg, rp2_reg, rp3_reg, rp4_reg;
    logic [15:0]        rh1_reg, rh2_reg, rh3_reg, rh4_reg;

    assign xt      = $signed({2'b00, in_item.raw_temperature[19:3]})
                   - $signed({2'b00, cal.t1, 1'b0});
    assign va_full = 35'(xt) * 35'(cal.t2);
    assign td      = $signed({2'b00, in_item.raw_temperature[19:4]}) - $signed({2'b00, cal.t1});
    assign dd_full = 36'(td) * 36'(td);

    logic signed [31:0] dd_sh;
    logic signed [47:0] mt_full;
    logic signed [31:0] ta_reg, mt_reg;
    assign dd_sh   = dd_reg >>> 12;
    assign mt_full = 48'(dd_sh) * 48'(cal.t3);

    logic signed [31:0] tfine_next, tfine_reg;
    assign tfine_next = ta_reg + (mt_reg >>> 14);

    logic signed [31:0] tf5, tsum, temp_next, temp4_reg;
    logic signed [63:0] tfine_w, pa_next, pa_reg;
    logic signed [31:0] hx_next, hx_reg;
    assign tf5       = (tfine_reg <<< 2) + tfine_reg;
    assign tsum      = tf5 + ptc_pkg::TEMP_ROUND;
    assign temp_next = tsum >>> 8;
    assign tfine_w   = 64'(tfine_reg);
    assign pa_next   = tfine_w - ptc_pkg::PRESS_TFINE_OFS;
    assign hx_next   = tfine_reg - ptc_pkg::HUM_TFINE_OFS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            va_reg    <= va_full[31:0];
            dd_reg    <= dd_full[31:0];
            rp1_reg   <= in_item.raw_pressure;
            rh1_reg   <= in_item.raw_humidity;
            ta_reg    <= va_reg >>> 11;
            mt_reg    <= mt_full[31:0];
            rp2_reg   <= rp1_reg;
            rh2_reg   <= rh1_reg;
            tfine_reg <= tfine_next;
            rp3_reg   <= rp2_reg;
            rh3_reg   <= rh2_reg;
            temp4_reg <= temp_next;
            pa_reg    <= pa_next;
            hx_reg    <= hx_next;
            rp4_reg   <= rp3_reg;
            rh4_reg   <= rh3_reg;
        end
    end

    // ---------------- pressure, ahead of the divider ----------------
    logic [63:0] aa, ap5, ap2, b1, aap3, a3full, num;

    ptc_mul64 u_mul_aa  (.clk(clk), .en(en), .a(pa_reg), .b(pa_reg), .p(aa));
    ptc_mul64 u_mul_ap5 (.clk(clk), .en(en), .a(pa_reg), .b(p5_w),   .p(ap5));
    ptc_mul64 u_mul_ap2 (.clk(clk), .en(en), .a(pa_reg), .b(p2_w),   .p(ap2));
    ptc_mul64 u_mul_b1  (.clk(clk), .en(en), .a(aa),     .b(p6_w),   .p(b1));
    ptc_mul64 u_mul_ap3 (.clk(clk), .en(en), .a(aa),     .b(p3_w),   .p(aap3));

    logic [19:0]        rp5_reg, rp6_reg, rp7_reg, rp8_reg;
    logic [63:0]        ap5a_reg, ap5b_reg, ap2a_reg, ap2b_reg;
    logic signed [63:0] aap3_s, b_next, am_next, b_reg, am_reg, numpre;
    logic [63:0]        pb_reg;
    logic [20:0]        pbase;

    assign aap3_s  = aap3;
    assign b_next  = b1 + (ap5b_reg << 17) + (p4_w <<< 35);
    assign am_next = ptc_pkg::PRESS_BIAS + (aap3_s >>> 8) + $signed(ap2b_reg << 12);
    assign pbase   = ptc_pkg::PRESS_FULL - {1'b0, rp8_reg};
    assign numpre  = pb_reg - b_reg;

    ptc_mul64 u_mul_a3  (.clk(clk), .en(en), .a(am_reg), .b(p1_w), .p(a3full));
    ptc_mul64 u_mul_num (.clk(clk), .en(en), .a(numpre), .b(ptc_pkg::PRESS_SCALE), .p(num));

    logic signed [30:0] a3;
    logic [63:0]        nmag_reg;
    logic [30:0]        dmag_reg;
    logic               zero_reg, neg_reg;
    assign a3 = a3full[63:33];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rp5_reg  <= rp4_reg;
            rp6_reg  <= rp5_reg;
            rp7_reg  <= rp6_reg;
            rp8_reg  <= rp7_reg;
            ap5a_reg <= ap5;
            ap5b_reg <= ap5a_reg;
            ap2a_reg <= ap2;
            ap2b_reg <= ap2a_reg;
            b_reg    <= b_next;
            am_reg   <= am_next;
            pb_reg   <= {12'd0, pbase, 31'd0};
            nmag_reg <= num[63] ? (64'd0 - num) : num;
            dmag_reg <= a3[30] ? (31'd0 - a3) : a3;
            zero_reg <= (a3 == '0);
            neg_reg  <= num[63] ^ a3[30];
        end
    end

    // ---------------- humidity ----------------
    logic [7:0]         hv_reg;
    logic signed [31:0] htemp_reg [8];
    logic signed [43:0] hx5_full;
    logic signed [39:0] xh6_full;
    logic signed [40:0] xh3_full;
    logic signed [31:0] hx5_reg, xh6_reg, xh3_reg;
    logic [15:0]        rhh_reg;

    assign hx5_full = 44'(cal.h5) * 44'(hx_reg);
    assign xh6_full = 40'(hx_reg) * 40'(cal.h6);
    assign xh3_full = 41'(hx_reg) * 41'($signed({1'b0, cal.h3}));

    logic signed [31:0] lsum, left2_reg, ha_reg, hb_reg;
    assign lsum = $signed({2'b00, rhh_reg, 14'd0}) - $signed({cal.h4, 20'd0})
                - hx5_reg + ptc_pkg::HUM_ROUND_L;

    logic signed [63:0] ab_full;
    logic signed [31:0] ab_reg, left3_reg;
    assign ab_full = 64'(ha_reg) * 64'(hb_reg);

    logic signed [31:0] hc;
    logic signed [47:0] ch2_full;
    logic signed [31:0] ch2_reg, left4_reg;
    assign hc       = (ab_reg >>> 10) + ptc_pkg::HUM_OFS_C;
    assign ch2_full = 48'(hc) * 48'(cal.h2);

    logic signed [31:0] rsum, right;
    logic signed [63:0] xm_full;
    logic signed [31:0] xm_reg;
    assign rsum    = ch2_reg + ptc_pkg::HUM_ROUND_R;
    assign right   = rsum >>> 14;
    assign xm_full = 64'(left4_reg) * 64'(right);

    logic signed [31:0] xs;
    logic signed [63:0] sq_full;
    logic signed [31:0] sq_reg, xm6_reg;
    assign xs      = xm_reg >>> 15;
    assign sq_full = 64'(xs) * 64'(xs);

    logic signed [31:0] sq_sh;
    logic signed [40:0] tt_full;
    logic signed [31:0] tt_reg, xm7_reg;
    assign sq_sh   = sq_reg >>> 7;
    assign tt_full = 41'(sq_sh) * 41'($signed({1'b0, cal.h1}));

    logic signed [31:0] x2, x2c;
    logic [16:0]        hum_reg;
    assign x2 = xm7_reg - (tt_reg >>> 4);

    always_comb
    begin
        x2c = x2;
        if (x2 < 0)
        begin
            x2c = '0;
        end
        else if (x2 > ptc_pkg::HUM_MAX)
        begin
            x2c = ptc_pkg::HUM_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hx5_reg   <= hx5_full[31:0];
            xh6_reg   <= xh6_full[31:0];
            xh3_reg   <= xh3_full[31:0];
            rhh_reg   <= rh4_reg;
            left2_reg <= lsum >>> 15;
            ha_reg    <= xh6_reg >>> 10;
            hb_reg    <= (xh3_reg >>> 11) + ptc_pkg::HUM_OFS_B;
            ab_reg    <= ab_full[31:0];
            left3_reg <= left2_reg;
            ch2_reg   <= ch2_full[31:0];
            left4_reg <= left3_reg;
            xm_reg    <= xm_full[31:0];
            sq_reg    <= sq_full[31:0];
            xm6_reg   <= xm_reg;
            tt_reg    <= tt_full[31:0];
            xm7_reg   <= xm6_reg;
            hum_reg   <= x2c[28:12];
            htemp_reg[0] <= temp4_reg;
            for (int k = 1; k < 8; k++)
            begin
                htemp_reg[k] <= htemp_reg[k-1];
            end
        end
    end

    // ---------------- divider ----------------
    ptc_pkg::side_t div_side_in, div_side_out;
    logic           div_vld;
    logic [63:0]    quo;

    assign div_side_in.temp = htemp_reg[7];
    assign div_side_in.hum  = hum_reg;
    assign div_side_in.zero = zero_reg;
    assign div_side_in.neg  = neg_reg;

    ptc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (hv_reg[7]),
        .num      (nmag_reg),
        .den      (dmag_reg),
        .in_side  (div_side_in),
        .out_vld  (div_vld),
        .quo      (quo),
        .out_side (div_side_out)
    );

    // ---------------- pressure, after the divider ----------------
    logic signed [63:0] pd_reg, ps_d;
    ptc_pkg::side_t     sd_reg;
    logic signed [63:0] pm_reg [4];
    ptc_pkg::side_t     sm_reg [4];
    logic [63:0]        c1, d1, c2, d1a_reg, d1b_reg;
    logic signed [63:0] ps_m;
    logic [4:0]         vp_reg;

    assign ps_d = pd_reg >>> 13;
    assign ps_m = pm_reg[1] >>> 13;

    ptc_mul64 u_mul_c1 (.clk(clk), .en(en), .a(p9_w), .b(ps_d),   .p(c1));
    ptc_mul64 u_mul_d1 (.clk(clk), .en(en), .a(p8_w), .b(pd_reg), .p(d1));
    ptc_mul64 u_mul_c2 (.clk(clk), .en(en), .a(c1),   .b(ps_m),   .p(c2));

    logic signed [63:0] c2_s, d1_s, psum, pf;
    logic [31:0]        press_next;
    assign c2_s       = c2;
    assign d1_s       = d1b_reg;
    assign psum       = pm_reg[3] + (c2_s >>> 25) + (d1_s >>> 19);
    assign pf         = (psum >>> 8) + (p7_w <<< 4);
    assign press_next = sm_reg[3].zero ? 32'd0 : pf[31:0];

    logic signed [31:0] temp_out_reg;
    logic [31:0]        press_out_reg;
    logic [16:0]        hum_out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd_reg    <= div_side_out.neg ? (64'sd0 - $signed(quo)) : $signed(quo);
            sd_reg    <= div_side_out;
            pm_reg[0] <= pd_reg;
            sm_reg[0] <= sd_reg;
            for (int k = 1; k < 4; k++)
            begin
                pm_reg[k] <= pm_reg[k-1];
                sm_reg[k] <= sm_reg[k-1];
            end
            d1a_reg       <= d1;
            d1b_reg       <= d1a_reg;
            temp_out_reg  <= sm_reg[3].temp;
            press_out_reg <= press_next;
            hum_out_reg   <= sm_reg[3].hum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            hv_reg      <= '0;
            vp_reg      <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg      <= in_vld;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            hv_reg      <= {hv_reg[6:0], v4_reg};
            vp_reg      <= {vp_reg[3:0], div_vld};
            out_vld_reg <= vp_reg[4];
        end
    end

    assign out_vld     = out_vld_reg;
    assign temperature = temp_out_reg;
    assign pressure    = press_out_reg;
    assign humidity    = hum_out_reg;

endmodule

[design/pressure_temp_humidity_compensation_core.sv]
// Top level of the compensation core: calibration registers, input queue and compute pipeline.
// Depends on ptc_pkg, ptc_front and ptc_back.
//
// Takes one raw reading per cycle while the output is not stalled, and returns one
// compensated result per reading, in order. A reading passes through the input queue, the
// temperature stages, the pressure and humidity products, the bit-per-stage pressure divider,
// and the final pressure terms and output register. Calibration writes take effect at once
// and must only be made while no item is in flight.
module pressure_temp_humidity_compensation_core
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [19:0]                      raw_pressure,
    input  logic [19:0]                      raw_temperature,
    input  logic [15:0]                      raw_humidity,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [31:0]               temperature,
    output logic [31:0]                      pressure,
    output logic [16:0]                      humidity,
    input  logic                             cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [47:0] temp_calib_reg;
    logic [63:0] press_calib_low_reg;
    logic [63:0] press_calib_high_reg;
    logic [47:0] press_hum_calib_reg;
    logic [31:0] hum_calib_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg       <= '0;
            press_calib_low_reg  <= '0;
            press_calib_high_reg <= '0;
            press_hum_calib_reg  <= '0;
            hum_calib_reg        <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ptc_pkg::REG_TEMP_CALIB:       temp_calib_reg       <= cfg_data[47:0];
                ptc_pkg::REG_PRESS_CALIB_LOW:  press_calib_low_reg  <= cfg_data;
                ptc_pkg::REG_PRESS_CALIB_HIGH: press_calib_high_reg <= cfg_data;
                ptc_pkg::REG_PRESS_HUM_CALIB:  press_hum_calib_reg  <= cfg_data[47:0];
                ptc_pkg::REG_HUM_CALIB:        hum_calib_reg        <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    ptc_pkg::calib_t cal;
    assign cal.t1 = temp_calib_reg[15:0];
    assign cal.t2 = temp_calib_reg[31:16];
    assign cal.t3 = temp_calib_reg[47:32];
    assign cal.p1 = press_calib_low_reg[15:0];
    assign cal.p2 = press_calib_low_reg[31:16];
    assign cal.p3 = press_calib_low_reg[47:32];
    assign cal.p4 = press_calib_low_reg[63:48];
    assign cal.p5 = press_calib_high_reg[15:0];
    assign cal.p6 = press_calib_high_reg[31:16];
    assign cal.p7 = press_calib_high_reg[47:32];
    assign cal.p8 = press_calib_high_reg[63:48];
    assign cal.p9 = press_hum_calib_reg[15:0];
    assign cal.h1 = press_hum_calib_reg[23:16];
    assign cal.h2 = press_hum_calib_reg[39:24];
    assign cal.h3 = press_hum_calib_reg[47:40];
    assign cal.h4 = hum_calib_reg[11:0];
    assign cal.h5 = hum_calib_reg[23:12];
    assign cal.h6 = hum_calib_reg[31:24];

    ptc_pkg::raw_t in_item;
    ptc_pkg::raw_t q_item;
    logic          q_vld;
    logic          q_take;

    assign in_item.raw_pressure    = raw_pressure;
    assign in_item.raw_temperature = raw_temperature;
    assign in_item.raw_humidity    = raw_humidity;

    ptc_front #(.DEPTH(QUEUE_DEPTH)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_vld    (q_vld),
        .q_item   (q_item),
        .q_take   (q_take)
    );

    ptc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cal         (cal),
        .in_vld      (q_vld),
        .in_item     (q_item),
        .in_take     (q_take),
        .out_vld     (out_valid),
        .out_stall   (out_stall),
        .temperature (temperature),
        .pressure    (pressure),
        .humidity    (humidity)
    );

endmodule

[design/ptc_checker.sv]
// Port-level checks for the compensation core, bound to the top level.
// Depends only on the top level's ports.
module ptc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] temperature,
    input logic [31:0] pressure,
    input logic [16:0] humidity
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(temperature) && $stable(pressure) && $stable(humidity))
        else $error("result changed while stalled");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> humidity <= 17'd102400)
        else $error("humidity above full scale");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid && out_stall))
        else $error("input stalled without output back-pressure");

endmodule

bind pressure_temp_humidity_compensation_core ptc_checker u_ptc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .temperature (temperature),
    .pressure    (pressure),
    .humidity    (humidity)
);

[tb/testbench.sv]
// Self-checking testbench for pressure_temp_humidity_compensation_core.
// Predicts temperature, pressure and humidity per item and checks them in order; uses ptc_pkg.
module testbench;

    localparam logic [ptc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 120;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        logic signed [31:0] temp;
        logic [31:0]        press;
        logic [16:0]        hum;
    } reading_t;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [19:0]                      raw_pressure;
    logic [19:0]                      raw_temperature;
    logic [15:0]                      raw_humidity;
    logic                             out_valid;
    logic                             out_stall;
    logic signed [31:0]               temperature;
    logic [31:0]                      pressure;
    logic [16:0]                      humidity;
    logic                             cfg_we;
    logic [ptc_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [ptc_pkg::CFG_DATA_W-1:0]   cfg_data;

    logic [47:0] cal_temp;
    logic [63:0] cal_press_lo;
    logic [63:0] cal_press_hi;
    logic [47:0] cal_press_hum;
    logic [31:0] cal_hum;

    reading_t expected_q[$];
    int errors;
    int items_sent;
    int readings_checked;
    int burst_left;
    int gap_max;
    int stall_pct;
    bit hold_req;
    int hold_len;
    int idle_count;

    pressure_temp_humidity_compensation_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .raw_pressure(raw_pressure), .raw_temperature(raw_temperature),
        .raw_humidity(raw_humidity),
        .out_valid(out_valid), .out_stall(out_stall),
        .temperature(temperature), .pressure(pressure), .humidity(humidity),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic reading_t compensate(input logic [19:0] rp, input logic [19:0] rt,
                                            input logic [15:0] rh);
        logic signed [31:0] at, ah, t1s, t2s, t3s, a, b, c, d, tf, x, lft, rgt;
        logic signed [31:0] h1s, h2s, h3s, h4s, h5s, h6s;
        logic signed [63:0] pa, pb, pc, pd, num, p, tf6, rp6;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        reading_t r;
        at  = {12'd0, rt};
        ah  = {16'd0, rh};
        t1s = {16'd0, cal_temp[15:0]};
        t2s = $signed(cal_temp[31:16]);
        t3s = $signed(cal_temp[47:32]);
        p1  = {48'd0, cal_press_lo[15:0]};
        p2  = $signed(cal_press_lo[31:16]);
        p3  = $signed(cal_press_lo[47:32]);
        p4  = $signed(cal_press_lo[63:48]);
        p5  = $signed(cal_press_hi[15:0]);
        p6  = $signed(cal_press_hi[31:16]);
        p7  = $signed(cal_press_hi[47:32]);
        p8  = $signed(cal_press_hi[63:48]);
        p9  = $signed(cal_press_hum[15:0]);
        h1s = {24'd0, cal_press_hum[23:16]};
        h2s = $signed(cal_press_hum[39:24]);
        h3s = {24'd0, cal_press_hum[47:40]};
        h4s = $signed(cal_hum[11:0]);
        h5s = $signed(cal_hum[23:12]);
        h6s = $signed(cal_hum[31:24]);

        a  = (((at >>> 3) - (t1s <<< 1)) * t2s) >>> 11;
        d  = (at >>> 4) - t1s;
        b  = (((d * d) >>> 12) * t3s) >>> 14;
        tf = a + b;
        r.temp = (tf * 32'sd5 + 32'sd128) >>> 8;

        tf6 = tf;
        rp6 = {44'd0, rp};
        pa = tf6 - 64'sd128000;
        pb = pa * pa * p6 + ((pa * p5) <<< 17) + (p4 <<< 35);
        pa = ((pa * pa * p3) >>> 8) + ((pa * p2) <<< 12);
        pa = (((64'sd1 <<< 47) + pa) * p1) >>> 33;
        if (pa == 64'sd0)
        begin
            r.press = 32'd0;
        end
        else
        begin
            num = (((64'sd1048576 - rp6) <<< 31) - pb) * 64'sd3125;
            if (pa == -64'sd1)
                p = 64'sd0 - num;
            else
                p = num / pa;
            pc = ((p9 * (p >>> 13)) * (p >>> 13)) >>> 25;
            pd = (p8 * p) >>> 19;
            p  = ((p + pc + pd) >>> 8) + (p7 <<< 4);
            r.press = p[31:0];
        end

        x   = tf - 32'sd76800;
        lft = (((ah <<< 14) - (h4s <<< 20) - h5s * x) + 32'sd16384) >>> 15;
        a   = (x * h6s) >>> 10;
        b   = ((x * h3s) >>> 11) + 32'sd32768;
        c   = ((a * b) >>> 10) + 32'sd2097152;
        rgt = (c * h2s + 32'sd8192) >>> 14;
        x   = lft * rgt;
        x   = x - (((((x >>> 15) * (x >>> 15)) >>> 7) * h1s) >>> 4);
        if (x < 0)
            x = 0;
        if (x > 32'sd419430400)
            x = 32'sd419430400;
        r.hum = x[28:12];
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with no item outstanding: temperature %0d pressure %0d humidity %0d",
                       temperature, pressure, humidity);
                errors++;
            end
            else
            begin
                reading_t e;
                e = expected_q.pop_front();
                readings_checked++;
                if (temperature !== e.temp)
                begin
                    $error("temperature: expected %0d, actual %0d", e.temp, temperature);
                    errors++;
                end
                if (pressure !== e.press)
                begin
                    $error("pressure: expected %0d, actual %0d", e.press, pressure);
                    errors++;
                end
                if (humidity !== e.hum)
                begin
                    $error("humidity: expected %0d, actual %0d", e.hum, humidity);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (!in_valid && expected_q.size() == 0))
        begin
            idle_count <= 0;
        end
        else if (idle_count >= STALL_LIMIT)
        begin
            $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            idle_count <= idle_count + 1;
        end
    end

    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
                @(posedge clk);
            end
        end
    end

    task automatic send_item(input logic [19:0] rp, input logic [19:0] rt, input logic [15:0] rh);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid        <= 1'b1;
        raw_pressure    <= rp;
        raw_temperature <= rt;
        raw_humidity    <= rh;
        do
            @(posedge clk);
        while (in_stall);
        expected_q.push_back(compensate(rp, rt, rh));
        items_sent++;
    endtask

    task automatic send_random_item();
        send_item(20'($urandom), 20'($urandom), 16'($urandom));
    endtask

    task automatic send_typical_item();
        send_item(20'($urandom_range(200000, 600000)), 20'($urandom_range(400000, 600000)),
                  16'($urandom_range(20000, 40000)));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ptc_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ptc_pkg::REG_TEMP_CALIB:       cal_temp      = value[47:0];
            ptc_pkg::REG_PRESS_CALIB_LOW:  cal_press_lo  = value;
            ptc_pkg::REG_PRESS_CALIB_HIGH: cal_press_hi  = value;
            ptc_pkg::REG_PRESS_HUM_CALIB:  cal_press_hum = value[47:0];
            ptc_pkg::REG_HUM_CALIB:        cal_hum       = value[31:0];
            default: ;
        endcase
    endtask

    task automatic load_calib(input logic [63:0] tc, input logic [63:0] pl, input logic [63:0] ph,
                              input logic [63:0] phc, input logic [63:0] hc);
        wait_drained();
        write_reg(ptc_pkg::REG_TEMP_CALIB, tc);
        write_reg(ptc_pkg::REG_PRESS_CALIB_LOW, pl);
        write_reg(ptc_pkg::REG_PRESS_CALIB_HIGH, ph);
        write_reg(ptc_pkg::REG_PRESS_HUM_CALIB, phc);
        write_reg(ptc_pkg::REG_HUM_CALIB, hc);
    endtask

    task automatic load_typical_calib();
        load_calib(64'({16'hFC18, 16'd26435, 16'd27504}),
                   {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                   {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                   64'({8'd0, 16'd362, 8'd75, 16'd6000}),
                   64'({8'd30, 12'd0, 12'd324}));
    endtask

    task automatic load_random_calib();
        load_calib({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    task automatic test_reset_calib();
        send_item(20'd0, 20'd0, 16'd0);
        send_item(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_item(20'h55555, 20'hAAAAA, 16'h5A5A);
    endtask

    task automatic test_field_extremes();
        load_typical_calib();
        send_item(20'd0, 20'd519888, 16'd30000);
        send_item(20'hFFFFF, 20'd519888, 16'd30000);
        send_item(20'd415148, 20'd0, 16'd30000);
        send_item(20'd415148, 20'hFFFFF, 16'd30000);
        send_item(20'd415148, 20'd519888, 16'd0);
        send_item(20'd415148, 20'd519888, 16'hFFFF);
        send_item(20'd415148, 20'd519888, 16'd30000);
        send_item(20'hAAAAA, 20'h55555, 16'hAAAA);
        send_item(20'h55555, 20'hAAAAA, 16'h5555);
    endtask

    task automatic test_zero_divisor();
        load_calib(64'({16'hFC18, 16'd26435, 16'd27504}),
                   {16'd2855, 16'd3024, 16'hD643, 16'd0},
                   {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                   64'({8'd0, 16'd362, 8'd75, 16'd6000}), 64'({8'd30, 12'd0, 12'd324}));
        send_item(20'd415148, 20'd519888, 16'd30000);
        send_item(20'hFFFFF, 20'd0, 16'hFFFF);
    endtask

    task automatic test_all_ones_calib();
        load_calib('1, '1, '1, '1, '1);
        write_reg(REG_UNUSED, 64'h0123_4567_89AB_CDEF);
        send_item(20'd0, 20'd0, 16'd0);
        send_item(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_item(20'd415148, 20'd519888, 16'd30000);
    endtask

    task automatic test_typical_random(input int count);
        load_typical_calib();
        repeat (count)
        begin
            if ($urandom_range(0, 9) < 8)
                send_typical_item();
            else
                send_random_item();
        end
    endtask

    task automatic test_random_calib(input int phases, input int count);
        repeat (phases)
        begin
            load_random_calib();
            repeat (count) send_random_item();
        end
    endtask

    task automatic test_backpressure();
        load_typical_calib();
        hold_len = 300;
        hold_req = 1'b1;
        repeat (150) send_typical_item();
        wait_drained();
        gap_max = 0;
        stall_pct = 0;
        repeat (40) send_typical_item();
        gap_max = 6;
        stall_pct = 30;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        raw_pressure = '0;
        raw_temperature = '0;
        raw_humidity = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cal_temp = '0;
        cal_press_lo = '0;
        cal_press_hi = '0;
        cal_press_hum = '0;
        cal_hum = '0;
        errors = 0;
        items_sent = 0;
        readings_checked = 0;
        burst_left = 0;
        gap_max = 6;
        stall_pct = 30;
        hold_req = 1'b0;
        hold_len = 0;
        idle_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_calib();
        test_field_extremes();
        test_zero_divisor();
        test_all_ones_calib();
        test_backpressure();
        test_typical_random(60);
        test_random_calib(5, 30);

        wait_drained();
        $display("Sent %0d items, checked %0d readings over reset, typical, zero-divisor,",
                 items_sent, readings_checked);
        $display("all-ones and random calibrations with input and output backpressure");
        if (errors == 0 && expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

[sim.f]
design/ptc_pkg.sv
design/ptc_mul64.sv
design/ptc_div.sv
design/ptc_front.sv
design/ptc_back.sv
design/pressure_temp_humidity_compensation_core.sv
design/ptc_checker.sv
tb/testbench.sv
